>>> hdl/rip_pkg.sv
// Shared types, codes and helpers for the regex infix-to-postfix unit.
`default_nettype none

package rip_pkg;

  // Default operator stack depth (legal range 2 to 62).
  localparam int DEFAULT_STACK_DEPTH = 32;

  // Depth of the word queue between front and back; must be a power of two.
  localparam int QUEUE_DEPTH = 4;
  localparam int QUEUE_AW    = $clog2(QUEUE_DEPTH);

  // Pattern characters that act as operators.
  localparam logic [7:0] CHAR_REP   = 8'h2B;  // '+'
  localparam logic [7:0] CHAR_CAT   = 8'h2E;  // '.'
  localparam logic [7:0] CHAR_ALT   = 8'h7C;  // '|'
  localparam logic [7:0] CHAR_OPEN  = 8'h28;  // '('
  localparam logic [7:0] CHAR_CLOSE = 8'h29;  // ')'

  // Stack codes; a code's value is its precedence.
  typedef logic [1:0] op_code_t;
  localparam op_code_t OP_OPEN = 2'd0;
  localparam op_code_t OP_ALT  = 2'd1;
  localparam op_code_t OP_CAT  = 2'd2;
  localparam op_code_t OP_REP  = 2'd3;

  // Error codes on the closing word.
  localparam logic [1:0] ERR_NONE     = 2'd0;
  localparam logic [1:0] ERR_PAREN    = 2'd1;
  localparam logic [1:0] ERR_OVERFLOW = 2'd2;

  // Character classes found by the front end.
  typedef enum logic [1:0] {
    CLS_LIT,
    CLS_OPEN,
    CLS_CLOSE,
    CLS_OP
  } cls_e;

  // One classified pattern word as it travels through the queue.
  typedef struct packed {
    logic [7:0] data;
    logic       is_final;
    cls_e       cls;
    op_code_t   code;
  } item_t;

  // Maps a stack code back to its pattern character.
  function automatic logic [7:0] code_to_char(op_code_t code);
    logic [7:0] ch;
    unique case (code)
      OP_OPEN: ch = CHAR_OPEN;
      OP_ALT:  ch = CHAR_ALT;
      OP_CAT:  ch = CHAR_CAT;
      default: ch = CHAR_REP;
    endcase
    return ch;
  endfunction

endpackage

`default_nettype wire

>>> hdl/regex_infix_to_postfix_unit.sv
// An accepted word is registered in a four-entry queue, then in the back end's current-word
// register; its postfix words leave through the output register. The back-end sequencer
// takes a literal through its idle and main states; an operator first pops each stacked
// operator of higher precedence, then is pushed; an inserted concatenation adds its own
// pop-then-push state; a final word adds a stack flush, an empty check and the closing word.
// Reset clears all control state; stack memory contents stay undefined until written.
`default_nettype none

module regex_infix_to_postfix_unit import rip_pkg::*; #(
  parameter int STACK_DEPTH = DEFAULT_STACK_DEPTH
) (
  input  wire logic       clk_i,
  input  wire logic       rst_ni,
  input  wire logic       in_valid_i,
  output logic            in_ready_o,
  input  wire logic [7:0] pattern_byte_i,
  input  wire logic       is_final_i,
  output logic            out_valid_o,
  input  wire logic       out_ready_i,
  output logic [7:0]      postfix_byte_o,
  output logic            has_byte_o,
  output logic            end_of_pattern_o,
  output logic [1:0]      error_code_o
);

  logic  f_valid;
  logic  f_ready;
  item_t f_item;
  logic  b_valid;
  logic  b_ready;
  item_t b_item;

  // Classify incoming words.
  rip_front u_front (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .in_valid_i     (in_valid_i),
    .in_ready_o     (in_ready_o),
    .pattern_byte_i (pattern_byte_i),
    .is_final_i     (is_final_i),
    .q_valid_o      (f_valid),
    .q_ready_i      (f_ready),
    .q_item_o       (f_item)
  );

  // Decoupling queue.
  rip_queue u_queue (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .push_valid_i (f_valid),
    .push_ready_o (f_ready),
    .push_item_i  (f_item),
    .pop_valid_o  (b_valid),
    .pop_ready_i  (b_ready),
    .pop_item_o   (b_item)
  );

  // Shunting-yard back end.
  rip_back #(
    .STACK_DEPTH (STACK_DEPTH)
  ) u_back (
    .clk_i            (clk_i),
    .rst_ni           (rst_ni),
    .q_valid_i        (b_valid),
    .q_ready_o        (b_ready),
    .q_item_i         (b_item),
    .out_valid_o      (out_valid_o),
    .out_ready_i      (out_ready_i),
    .postfix_byte_o   (postfix_byte_o),
    .has_byte_o       (has_byte_o),
    .end_of_pattern_o (end_of_pattern_o),
    .error_code_o     (error_code_o)
  );

endmodule

`default_nettype wire

>>> hdl/rip_front.sv
// Front end: accepts pattern words and classifies them for the back end.
`default_nettype none

module rip_front import rip_pkg::*; (
  input  wire logic       clk_i,
  input  wire logic       rst_ni,
  input  wire logic       in_valid_i,
  output logic            in_ready_o,
  input  wire logic [7:0] pattern_byte_i,
  input  wire logic       is_final_i,
  output logic            q_valid_o,
  input  wire logic       q_ready_i,
  output item_t           q_item_o
);

  logic word_seen_q;

  // A word passes on as soon as the queue has room.
  assign in_ready_o = q_ready_i;
  assign q_valid_o  = in_valid_i;

  // Sort the character into literal, parenthesis or operator.
  always_comb begin
    q_item_o.data     = pattern_byte_i;
    q_item_o.is_final = is_final_i;
    q_item_o.cls      = CLS_LIT;
    q_item_o.code     = OP_OPEN;
    unique case (pattern_byte_i)
      CHAR_OPEN: begin
        q_item_o.cls  = CLS_OPEN;
        q_item_o.code = OP_OPEN;
      end
      CHAR_CLOSE: begin
        q_item_o.cls  = CLS_CLOSE;
        q_item_o.code = OP_OPEN;
      end
      CHAR_REP: begin
        q_item_o.cls  = CLS_OP;
        q_item_o.code = OP_REP;
      end
      CHAR_CAT: begin
        q_item_o.cls  = CLS_OP;
        q_item_o.code = OP_CAT;
      end
      CHAR_ALT: begin
        q_item_o.cls  = CLS_OP;
        q_item_o.code = OP_ALT;
      end
      default: begin
        q_item_o.cls  = CLS_LIT;
        q_item_o.code = OP_OPEN;
      end
    endcase
  end

  // Tracks whether any word has entered since reset.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      word_seen_q <= 1'b0;
    end else if (in_valid_i && q_ready_i) begin
      word_seen_q <= 1'b1;
    end
  end

  // Every accepted word sets the word-seen flag.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    q_valid_o && q_ready_i |=> word_seen_q)
    else $error("front: accepted word not recorded");

  // A classified close parenthesis always carries the open code.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    q_valid_o && q_item_o.cls == CLS_CLOSE |-> q_item_o.code == OP_OPEN)
    else $error("front: close parenthesis with operator code");

  // Operators never carry the open-parenthesis code.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    q_valid_o && q_item_o.cls == CLS_OP |-> q_item_o.code != OP_OPEN)
    else $error("front: operator classified with open code");

endmodule

`default_nettype wire

>>> hdl/rip_queue.sv
// Short word queue that decouples the front end from the back end.
`default_nettype none

module rip_queue import rip_pkg::*; (
  input  wire logic  clk_i,
  input  wire logic  rst_ni,
  input  wire logic  push_valid_i,
  output logic       push_ready_o,
  input  wire item_t push_item_i,
  output logic       pop_valid_o,
  input  wire logic  pop_ready_i,
  output item_t      pop_item_o
);

  localparam int QCW = $clog2(QUEUE_DEPTH + 1);

  item_t                store_q [QUEUE_DEPTH];
  logic [QUEUE_AW-1:0]  wptr_q;
  logic [QUEUE_AW-1:0]  rptr_q;
  logic [QCW-1:0]       fill_q;
  logic                 push;
  logic                 pop;

  assign push_ready_o = (fill_q != QCW'(QUEUE_DEPTH));
  assign pop_valid_o  = (fill_q != '0);
  assign pop_item_o   = store_q[rptr_q];
  assign push         = push_valid_i && push_ready_o;
  assign pop          = pop_valid_o && pop_ready_i;

  // Pointers and fill level.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wptr_q <= '0;
      rptr_q <= '0;
      fill_q <= '0;
    end else begin
      if (push) begin
        wptr_q <= wptr_q + QUEUE_AW'(1);
      end
      if (pop) begin
        rptr_q <= rptr_q + QUEUE_AW'(1);
      end
      if (push && !pop) begin
        fill_q <= fill_q + QCW'(1);
      end else if (pop && !push) begin
        fill_q <= fill_q - QCW'(1);
      end
    end
  end

  // Word storage.
  always_ff @(posedge clk_i) begin
    if (push) begin
      store_q[wptr_q] <= push_item_i;
    end
  end

  // The fill level never passes the depth.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    fill_q <= QCW'(QUEUE_DEPTH))
    else $error("queue: fill level out of range");

  // A full queue without a pop stays full and loses no entry.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    fill_q == QCW'(QUEUE_DEPTH) && !pop |=> fill_q == QCW'(QUEUE_DEPTH))
    else $error("queue: full queue lost an entry");

  // Pointers stay apart by exactly the fill level.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    QUEUE_AW'(fill_q) == QUEUE_AW'(wptr_q - rptr_q))
    else $error("queue: pointers disagree with fill level");

endmodule

`default_nettype wire

>>> hdl/rip_back.sv
// Back end: shunting-yard sequencer with the operator stack and output register.
`default_nettype none

module rip_back import rip_pkg::*; #(
  parameter int STACK_DEPTH = DEFAULT_STACK_DEPTH
) (
  input  wire logic  clk_i,
  input  wire logic  rst_ni,
  input  wire logic  q_valid_i,
  output logic       q_ready_o,
  input  wire item_t q_item_i,
  output logic       out_valid_o,
  input  wire logic  out_ready_i,
  output logic [7:0] postfix_byte_o,
  output logic       has_byte_o,
  output logic       end_of_pattern_o,
  output logic [1:0] error_code_o
);

  localparam int AW = $clog2(STACK_DEPTH);
  localparam int CW = $clog2(STACK_DEPTH + 1);

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_CAT,
    ST_MAIN,
    ST_FLUSH,
    ST_CLOSE
  } state_e;

  state_e          state_q, state_d;
  item_t           cur_q, cur_d;
  logic [CW-1:0]   cnt_q, cnt_d;
  op_code_t        top_q, top_d;
  op_code_t        rd_q;
  logic            prev_q, prev_d;
  logic            disc_q, disc_d;
  logic [1:0]      err_q, err_d;

  // Stack entries below the top; the top itself lives in top_q.
  op_code_t        mem_q [STACK_DEPTH];

  logic            out_valid_q;
  logic [7:0]      out_byte_q;
  logic            out_has_q;
  logic            out_end_q;
  logic [1:0]      out_err_q;

  logic            out_free;
  logic            emit;
  logic [7:0]      e_byte;
  logic            e_has;
  logic            e_end;
  logic [1:0]      e_err;
  logic            do_push;
  logic            do_pop;
  logic            clear;
  op_code_t        push_code;
  op_code_t        pcode;
  logic            pop_hi;
  logic            full;
  logic            concat;
  state_e          after;
  logic            wr_en;
  logic [AW-1:0]   wr_addr;
  logic [CW-1:0]   rd_idx;
  logic [AW-1:0]   rd_addr;

  assign out_free = !out_valid_q || out_ready_i;
  assign pcode    = (state_q == ST_CAT) ? OP_CAT : cur_q.code;
  assign pop_hi   = (cnt_q != '0) && (top_q > pcode);
  assign full     = (cnt_q == CW'(STACK_DEPTH));
  assign concat   = prev_q && (q_item_i.cls == CLS_LIT || q_item_i.cls == CLS_OPEN);
  assign after    = cur_q.is_final ? ST_FLUSH : ST_IDLE;

  // Sequencer: one stack move or one emitted word per cycle, while the output register can take a word.
  always_comb begin
    state_d   = state_q;
    cur_d     = cur_q;
    prev_d    = prev_q;
    disc_d    = disc_q;
    err_d     = err_q;
    emit      = 1'b0;
    e_byte    = '0;
    e_has     = 1'b0;
    e_end     = 1'b0;
    e_err     = ERR_NONE;
    do_push   = 1'b0;
    do_pop    = 1'b0;
    clear     = 1'b0;
    push_code = OP_OPEN;
    q_ready_o = 1'b0;

    unique case (state_q)
      ST_IDLE: begin
        q_ready_o = 1'b1;
        if (q_valid_i) begin
          if (disc_q) begin
            // Words after an error are dropped up to the last one.
            if (q_item_i.is_final) begin
              disc_d = 1'b0;
            end
          end else begin
            cur_d   = q_item_i;
            state_d = concat ? ST_CAT : ST_MAIN;
          end
        end
      end

      ST_CAT: begin
        // Implicit concatenation goes through the same pop-then-push path.
        if (pop_hi) begin
          if (out_free) begin
            emit   = 1'b1;
            e_byte = code_to_char(top_q);
            e_has  = 1'b1;
            do_pop = 1'b1;
          end
        end else if (full) begin
          err_d   = ERR_OVERFLOW;
          state_d = ST_CLOSE;
        end else begin
          do_push   = 1'b1;
          push_code = OP_CAT;
          state_d   = ST_MAIN;
        end
      end

      ST_MAIN: begin
        unique case (cur_q.cls)
          CLS_LIT: begin
            if (out_free) begin
              emit    = 1'b1;
              e_byte  = cur_q.data;
              e_has   = 1'b1;
              prev_d  = 1'b1;
              state_d = after;
            end
          end
          CLS_OPEN: begin
            prev_d = 1'b0;
            if (full) begin
              err_d   = ERR_OVERFLOW;
              state_d = ST_CLOSE;
            end else begin
              do_push   = 1'b1;
              push_code = OP_OPEN;
              state_d   = after;
            end
          end
          CLS_CLOSE: begin
            // Pop down to the matching open parenthesis.
            if (cnt_q == '0) begin
              err_d   = ERR_PAREN;
              state_d = ST_CLOSE;
            end else if (top_q == OP_OPEN) begin
              do_pop  = 1'b1;
              prev_d  = 1'b1;
              state_d = after;
            end else if (out_free) begin
              emit   = 1'b1;
              e_byte = code_to_char(top_q);
              e_has  = 1'b1;
              do_pop = 1'b1;
            end
          end
          default: begin
            // Operator: pop higher precedence, then push.
            if (pop_hi) begin
              if (out_free) begin
                emit   = 1'b1;
                e_byte = code_to_char(top_q);
                e_has  = 1'b1;
                do_pop = 1'b1;
              end
            end else if (full) begin
              err_d   = ERR_OVERFLOW;
              state_d = ST_CLOSE;
            end else begin
              do_push   = 1'b1;
              push_code = cur_q.code;
              prev_d    = (cur_q.code == OP_REP);
              state_d   = after;
            end
          end
        endcase
      end

      ST_FLUSH: begin
        // Drain the stack at the end of the pattern.
        if (cnt_q == '0) begin
          state_d = ST_CLOSE;
        end else if (top_q == OP_OPEN) begin
          err_d   = ERR_PAREN;
          state_d = ST_CLOSE;
        end else if (out_free) begin
          emit   = 1'b1;
          e_byte = code_to_char(top_q);
          e_has  = 1'b1;
          do_pop = 1'b1;
        end
      end

      default: begin
        // Closing word, then a fresh start for the next pattern.
        if (out_free) begin
          emit    = 1'b1;
          e_end   = 1'b1;
          e_err   = err_q;
          clear   = 1'b1;
          prev_d  = 1'b0;
          disc_d  = (err_q != ERR_NONE) && !cur_q.is_final;
          err_d   = ERR_NONE;
          state_d = ST_IDLE;
        end
      end
    endcase
  end

  // Stack pointer and cached top.
  always_comb begin
    cnt_d = cnt_q;
    top_d = top_q;
    if (do_push) begin
      cnt_d = cnt_q + CW'(1);
      top_d = push_code;
    end else if (do_pop) begin
      cnt_d = cnt_q - CW'(1);
      top_d = rd_q;
    end
    if (clear) begin
      cnt_d = '0;
    end
  end

  // The old top spills to memory on a push; the entry below the new top is read ahead.
  assign wr_en   = do_push && (cnt_q != '0);
  assign wr_addr = AW'(cnt_q - CW'(1));
  assign rd_idx  = cnt_d - CW'(2);
  assign rd_addr = rd_idx[AW-1:0];

  always_ff @(posedge clk_i) begin
    if (wr_en) begin
      mem_q[wr_addr] <= top_q;
    end
    if (wr_en && wr_addr == rd_addr) begin
      rd_q <= top_q;
    end else begin
      rd_q <= mem_q[rd_addr];
    end
  end

  // Control state, stack top and the output register.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      cnt_q       <= '0;
      top_q       <= OP_OPEN;
      prev_q      <= 1'b0;
      disc_q      <= 1'b0;
      err_q       <= ERR_NONE;
      out_valid_q <= 1'b0;
    end else begin
      state_q <= state_d;
      cnt_q   <= cnt_d;
      top_q   <= top_d;
      prev_q  <= prev_d;
      disc_q  <= disc_d;
      err_q   <= err_d;
      if (emit) begin
        out_valid_q <= 1'b1;
      end else if (out_ready_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  // Current word and output payload.
  always_ff @(posedge clk_i) begin
    cur_q <= cur_d;
    if (emit) begin
      out_byte_q <= e_byte;
      out_has_q  <= e_has;
      out_end_q  <= e_end;
      out_err_q  <= e_err;
    end
  end

  assign out_valid_o      = out_valid_q;
  assign postfix_byte_o   = out_byte_q;
  assign has_byte_o       = out_has_q;
  assign end_of_pattern_o = out_end_q;
  assign error_code_o     = out_err_q;

  // The stack never holds more than its depth.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    cnt_q <= CW'(STACK_DEPTH))
    else $error("back: stack count beyond depth");

  // A word without a character is always a closing word.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !has_byte_o |-> end_of_pattern_o)
    else $error("back: bare word without end mark");

  // An error code shows up only on a bare closing word.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && error_code_o != ERR_NONE |-> end_of_pattern_o && !has_byte_o)
    else $error("back: error code on a data word");

  // Closing a pattern leaves an empty stack.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    emit && state_q == ST_CLOSE |=> cnt_q == '0 && !prev_q)
    else $error("back: state not cleared after close");

endmodule

`default_nettype wire

>>> verif/regex_infix_to_postfix_unit_tb.sv
// Self-checking testbench for the regex infix-to-postfix unit, with a built-in predictor.
`default_nettype none

module regex_infix_to_postfix_unit_tb;
  import rip_pkg::*;

  localparam int DEPTH     = DEFAULT_STACK_DEPTH;
  localparam int RANDOM_N  = 225;
  localparam int CALM_TAIL = 40;
  localparam int MAX_SHOWN = 40;

  // One pattern byte waiting to be sent; hold makes the sender drain first.
  typedef struct packed {
    logic [7:0] ch;
    logic       last;
    logic       hold;
  } pattern_item_t;

  // One postfix word as the unit should deliver it.
  typedef struct packed {
    logic [7:0] ch;
    logic       has;
    logic       eop;
    logic [1:0] err;
  } postfix_word_t;

  logic       clk_i          = 1'b0;
  logic       rst_ni         = 1'b0;
  logic       in_valid_i     = 1'b0;
  logic [7:0] pattern_byte_i = 8'h00;
  logic       is_final_i     = 1'b0;
  logic       out_ready_i    = 1'b0;
  logic       in_ready_o;
  logic       out_valid_o;
  logic [7:0] postfix_byte_o;
  logic       has_byte_o;
  logic       end_of_pattern_o;
  logic [1:0] error_code_o;

  regex_infix_to_postfix_unit #(
    .STACK_DEPTH(DEPTH)
  ) i_dut (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .in_valid_i      (in_valid_i),
    .in_ready_o      (in_ready_o),
    .pattern_byte_i  (pattern_byte_i),
    .is_final_i      (is_final_i),
    .out_valid_o     (out_valid_o),
    .out_ready_i     (out_ready_i),
    .postfix_byte_o  (postfix_byte_o),
    .has_byte_o      (has_byte_o),
    .end_of_pattern_o(end_of_pattern_o),
    .error_code_o    (error_code_o)
  );

  pattern_item_t pattern_q[$];
  postfix_word_t postfix_q[$];
  logic [7:0]    draft[$];
  int            mismatches = 0;

  // Predictor state: operator stack, its fill level and the pattern flags.
  op_code_t op_stack [DEPTH];
  int       op_top    = 0;
  bit       cat_ok    = 1'b0;
  bit       skipping  = 1'b0;

  logic [7:0] code_glyph [4] = '{CHAR_OPEN, CHAR_ALT, CHAR_CAT, CHAR_REP};
  logic [7:0] op_chars [5]   = '{CHAR_REP, CHAR_CAT, CHAR_ALT, CHAR_OPEN, CHAR_CLOSE};

  // Handshake and idling state shared by the driver, the receiver and the monitor.
  logic in_took  = 1'b0;
  bit   calm     = 1'b1;
  int   idle_pct = 10;
  int   send_gap = 0;
  int   recv_gap = 0;
  int   cycle_n  = 0;

  // Clock with a period of two time units.
  always begin
    clk_i = 1'b1;
    #1;
    clk_i = 1'b0;
    #1;
  end

  function automatic bit is_operator(logic [7:0] ch);
    return ch == CHAR_REP || ch == CHAR_CAT || ch == CHAR_ALT ||
           ch == CHAR_OPEN || ch == CHAR_CLOSE;
  endfunction

  function automatic void add_word(logic [7:0] ch, logic has, logic eop, logic [1:0] err);
    postfix_word_t w;
    w.ch  = ch;
    w.has = has;
    w.eop = eop;
    w.err = err;
    postfix_q.insert(postfix_q.size(), w);
  endfunction

  // Pops every stacked operator that binds tighter, then pushes the new one.
  function automatic logic [1:0] push_op_code(op_code_t code);
    while (op_top > 0 && op_stack[op_top-1] > code) begin
      op_top--;
      add_word(code_glyph[op_stack[op_top]], 1'b1, 1'b0, ERR_NONE);
    end
    if (op_top >= DEPTH) return ERR_OVERFLOW;
    op_stack[op_top] = code;
    op_top++;
    return ERR_NONE;
  endfunction

  // Works out the postfix words that one accepted pattern byte produces.
  function automatic void convert_byte(logic [7:0] ch, logic last);
    logic [1:0] err;
    bit         is_op;
    op_code_t   top;
    err = ERR_NONE;
    if (skipping) begin
      if (last) skipping = 1'b0;
      return;
    end
    is_op = is_operator(ch);
    // Implicit concatenation before a literal or an opening parenthesis.
    if ((!is_op || ch == CHAR_OPEN) && cat_ok) err = push_op_code(OP_CAT);
    if (err == ERR_NONE) begin
      if (!is_op) begin
        add_word(ch, 1'b1, 1'b0, ERR_NONE);
        cat_ok = 1'b1;
      end else if (ch == CHAR_OPEN) begin
        if (op_top >= DEPTH) begin
          err = ERR_OVERFLOW;
        end else begin
          op_stack[op_top] = OP_OPEN;
          op_top++;
        end
        cat_ok = 1'b0;
      end else if (ch == CHAR_CLOSE) begin
        forever begin
          if (op_top == 0) begin
            err = ERR_PAREN;
            break;
          end
          op_top--;
          top = op_stack[op_top];
          if (top == OP_OPEN) break;
          add_word(code_glyph[top], 1'b1, 1'b0, ERR_NONE);
        end
        cat_ok = 1'b1;
      end else begin
        err = push_op_code(ch == CHAR_REP ? OP_REP : ch == CHAR_CAT ? OP_CAT : OP_ALT);
        cat_ok = (ch == CHAR_REP);
      end
    end
    // The last byte flushes the stack; an open parenthesis left there is an error.
    if (err == ERR_NONE && last) begin
      while (op_top > 0) begin
        op_top--;
        top = op_stack[op_top];
        if (top == OP_OPEN) begin
          err = ERR_PAREN;
          break;
        end
        add_word(code_glyph[top], 1'b1, 1'b0, ERR_NONE);
      end
    end
    if (err != ERR_NONE || last) begin
      add_word(8'h00, 1'b0, 1'b1, err);
      op_top   = 0;
      cat_ok   = 1'b0;
      skipping = (err != ERR_NONE) && !last;
    end
  endfunction

  task automatic report(string msg);
    if (mismatches < MAX_SHOWN) $display("MISMATCH @%0t: %s", $realtime, msg);
    mismatches++;
  endtask

  // Compares one delivered word with the oldest predicted one.
  task automatic check_word(logic [7:0] ch, logic has, logic eop, logic [1:0] err);
    postfix_word_t w;
    if (postfix_q.size() == 0) begin
      report($sformatf("word %h has=%b eop=%b err=%0d with none predicted",
                       ch, has, eop, err));
      return;
    end
    w = postfix_q[0];
    postfix_q.delete(0);
    if (ch !== w.ch) report($sformatf("postfix_byte %h, predicted %h", ch, w.ch));
    if (has !== w.has) report($sformatf("has_byte %b, predicted %b", has, w.has));
    if (eop !== w.eop) report($sformatf("end_of_pattern %b, predicted %b", eop, w.eop));
    if (err !== w.err) report($sformatf("error_code %0d, predicted %0d", err, w.err));
  endtask

  // Stimulus builders.
  task automatic put(logic [7:0] ch, logic last, logic hold);
    pattern_item_t it;
    it.ch   = ch;
    it.last = last;
    it.hold = hold;
    pattern_q.insert(pattern_q.size(), it);
  endtask

  task automatic put_string(string s, logic hold);
    for (int i = 0; i < s.len(); i++) put(s[i], i == s.len() - 1, hold && i == 0);
  endtask

  function automatic logic [7:0] pick_literal();
    logic [7:0] ch;
    do ch = 8'($urandom_range(0, 255)); while (is_operator(ch));
    return ch;
  endfunction

  // Builds a well-formed pattern with random content into the draft buffer.
  task automatic build_regex(int max_len);
    int open_n;
    bit want_operand;
    int pick;
    draft.delete();
    open_n = 0;
    want_operand = 1'b1;
    while (draft.size() < max_len) begin
      pick = $urandom_range(0, 99);
      if (want_operand) begin
        if (pick < 25 && open_n < 6) begin
          draft.insert(draft.size(), CHAR_OPEN);
          open_n++;
        end else begin
          draft.insert(draft.size(), pick_literal());
          want_operand = 1'b0;
        end
      end else if (pick < 20) begin
        draft.insert(draft.size(), pick_literal());
      end else if (pick < 30 && open_n < 6) begin
        draft.insert(draft.size(), CHAR_OPEN);
        open_n++;
        want_operand = 1'b1;
      end else if (pick < 45) begin
        draft.insert(draft.size(), CHAR_REP);
      end else if (pick < 60) begin
        draft.insert(draft.size(), CHAR_ALT);
        want_operand = 1'b1;
      end else if (pick < 70) begin
        draft.insert(draft.size(), CHAR_CAT);
        want_operand = 1'b1;
      end else if (pick < 90 && open_n > 0) begin
        draft.insert(draft.size(), CHAR_CLOSE);
        open_n--;
      end else if (pick >= 90) begin
        break;
      end
    end
    if (want_operand) draft.insert(draft.size(), pick_literal());
    while (open_n > 0) begin
      draft.insert(draft.size(), CHAR_CLOSE);
      open_n--;
    end
  endtask

  // Nests parentheses one short of or up to the stack depth, then adds a short random tail.
  task automatic build_deep();
    int tail;
    draft.delete();
    repeat ($urandom_range(DEPTH - 1, DEPTH)) draft.insert(draft.size(), CHAR_OPEN);
    tail = $urandom_range(1, 4);
    repeat (tail) begin
      if ($urandom_range(0, 2) == 0) draft.insert(draft.size(), pick_literal());
      else draft.insert(draft.size(), op_chars[$urandom_range(0, 4)]);
    end
  endtask

  // Damages a well-formed draft in one place.
  task automatic break_draft();
    int idx;
    idx = $urandom_range(0, draft.size() - 1);
    case ($urandom_range(0, 3))
      0: draft[idx] = op_chars[$urandom_range(0, 4)];
      1: if (draft.size() > 1) draft.delete(idx);
      2: draft.insert(0, CHAR_CLOSE);
      default: draft.insert(draft.size(), CHAR_OPEN);
    endcase
  endtask

  task automatic send_draft(logic hold);
    for (int i = 0; i < draft.size(); i++)
      put(draft[i], i == draft.size() - 1, hold && i == 0);
  endtask

  // Fills the pending queue: a directed part first, then random patterns.
  task automatic fill_stimulus();
    int   sent;
    int   kind;
    logic hold;
    // Smallest and largest literal, each as a whole pattern.
    put(8'h00, 1'b1, 1'b0);
    put(8'hFF, 1'b1, 1'b0);
    // Every operator, precedence order and implicit concatenation.
    put_string("(a|b)+c.d", 1'b0);
    // Concatenation inserted for ')(' and '+('.
    put_string("(a)(b)+(c)", 1'b0);
    // Unmatched close parenthesis mid-pattern; the final byte is then dropped.
    put_string(")x", 1'b1);
    // Unmatched open parenthesis found by the final flush.
    put_string("(", 1'b0);

    sent = 0;
    while (sent < RANDOM_N) begin
      kind = (sent == 0) ? 0 : $urandom_range(0, 99);
      hold = ($urandom_range(0, 15) == 0);
      if (kind < 4 || pattern_q.size() < 40 && sent < 40 && kind < 8) begin
        build_deep();
      end else if (kind < 76) begin
        build_regex($urandom_range(0, 9) == 0 ? 20 : $urandom_range(1, 8));
      end else if (kind < 90) begin
        build_regex($urandom_range(1, 8));
        break_draft();
      end else begin
        draft.delete();
        repeat ($urandom_range(1, 8)) begin
          if ($urandom_range(0, 1)) draft.insert(draft.size(), op_chars[$urandom_range(0, 4)]);
          else draft.insert(draft.size(), 8'($urandom_range(0, 255)));
        end
        // Noise may close a pattern early through a random final flag.
        for (int i = 0; i < draft.size() - 1; i++)
          if ($urandom_range(0, 3) == 0) begin
            put(draft[i], 1'b1, 1'b0);
            draft.delete(i);
            break;
          end
      end
      send_draft(hold);
      sent += draft.size();
    end
  endtask

  // Monitor: predicts on every accepted input byte and checks every delivered word.
  always @(posedge clk_i) begin
    if (rst_ni) begin
      in_took <= in_valid_i && in_ready_o;
      if (in_valid_i && in_ready_o) convert_byte(pattern_byte_i, is_final_i);
      if (out_valid_o && out_ready_i)
        check_word(postfix_byte_o, has_byte_o, end_of_pattern_o, error_code_o);
      calm <= (pattern_q.size() < CALM_TAIL);
      cycle_n <= cycle_n + 1;
      // Idling density changes now and then, with stretches of none at all.
      if (cycle_n % 64 == 0) begin
        case ($urandom_range(0, 2))
          0: idle_pct <= 0;
          1: idle_pct <= 10;
          default: idle_pct <= 30;
        endcase
      end
    end
  end

  // Driver: presents the next pending byte once the current one is taken.
  always @(negedge clk_i) begin
    logic          nv;
    pattern_item_t nx;
    if (rst_ni && (!in_valid_i || in_took)) begin
      nv = 1'b0;
      nx = '0;
      if (send_gap > 0) begin
        send_gap--;
      end else if (pattern_q.size() == 0) begin
        nv = 1'b0;
      end else if (pattern_q[0].hold && postfix_q.size() != 0) begin
        nv = 1'b0;
      end else if (!calm && $urandom_range(0, 99) < idle_pct) begin
        send_gap = $urandom_range(0, 5);
      end else begin
        nx = pattern_q[0];
        pattern_q.delete(0);
        nv = 1'b1;
      end
      in_valid_i <= nv;
      if (nv) begin
        pattern_byte_i <= nx.ch;
        is_final_i     <= nx.last;
      end
    end
  end

  // Receiver: ready with random stall bursts, none in the closing stretch.
  always @(negedge clk_i) begin
    logic rdy;
    rdy = 1'b1;
    if (recv_gap > 0) begin
      recv_gap--;
      rdy = 1'b0;
    end else if (!calm && $urandom_range(0, 99) < idle_pct) begin
      recv_gap = $urandom_range(0, 5);
      rdy = 1'b0;
    end
    out_ready_i <= rdy && rst_ni;
  end

  // Sequence: reset, run all stimulus, drain, then judge.
  initial begin
    fill_stimulus();
    repeat (11) @(negedge clk_i);
    rst_ni = 1'b1;
    while (pattern_q.size() != 0 || in_valid_i || postfix_q.size() != 0) @(posedge clk_i);
    repeat (40) @(negedge clk_i);
    if (postfix_q.size() != 0) report($sformatf("%0d predicted words never arrived",
                                                 postfix_q.size()));
    if (mismatches == 0) begin
      $display("regex_infix_to_postfix_unit_tb OK");
    end else begin
      $display("regex_infix_to_postfix_unit_tb NOT OK");
    end
    $finish;
  end

  // Watchdog for a hung handshake or words that never arrive.
  initial begin
    #400000;
    $display("regex_infix_to_postfix_unit_tb NOT OK");
    $finish;
  end

endmodule

`default_nettype wire
